// File: rtl/core/qte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// Shared widths, types, the arctangent table and helper functions of the
// quaternion to Euler angle unit.
// ----------------------------------------------------------------------------
package qte_pkg;

	localparam int TW   = 36;          // width of the quaternion product terms
	localparam int SW   = 30;          // width of the clamped asin argument
	localparam int XW   = 37;          // width of the CORDIC x and y registers
	localparam int AW   = 26;          // width of the angle accumulator
	localparam int SQW  = 58;          // width of the square root remainder
	localparam int CW   = 17;          // width of an angle in counts
	localparam int NSQ  = 29;          // square root steps
	localparam int NCOR = 22;          // CORDIC steps
	localparam int NFRONT = 3;         // product, term and radicand stages
	localparam int NST  = NFRONT + NSQ + 1 + NCOR + 1;
	localparam int NLANE = 3;

	localparam logic signed [AW-1:0] QUARTER_TURN = AW'(90 * 65536);
	localparam logic signed [CW-1:0] LIM_WIDE   = CW'(23040);
	localparam logic signed [CW-1:0] LIM_NARROW = CW'(11520);

	localparam logic [21:0] ATAN_TAB [NCOR] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
		22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
		22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2
	};

	typedef logic signed [TW-1:0] term_t;

	typedef struct packed {
		logic signed [SW-1:0] s;
		term_t yaw_n;
		term_t yaw_d;
		term_t rol_n;
		term_t rol_d;
	} side_t;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [AW-1:0] acc;
		logic                 zero;
	} cord_t;

	// Brings a vector into the right half plane before the CORDIC steps.
	function automatic cord_t pre_rotate(input logic signed [XW-1:0] y,
		input logic signed [XW-1:0] x);
		cord_t r;
		r.zero = (x == '0) && (y == '0);
		r.x    = x;
		r.y    = y;
		r.acc  = '0;
		if (x < 0) begin
			if (y >= 0) begin
				r.x   = y;
				r.y   = -x;
				r.acc = QUARTER_TURN;
			end else begin
				r.x   = -y;
				r.y   = x;
				r.acc = -QUARTER_TURN;
			end
		end
		return r;
	endfunction

	// Rounds acc to 1/128 degree, clamps it to +-lim; a zero vector gives 0.
	function automatic logic signed [CW-1:0] to_counts(input cord_t c,
		input logic signed [CW-1:0] lim);
		logic signed [AW:0]   sum;
		logic signed [AW-9:0] q;
		logic signed [CW-1:0] r;
		sum = (AW+1)'(c.acc) + (AW+1)'(256);
		q   = sum[AW:9];
		if (q > (AW-8)'(lim))
			r = lim;
		else if (q < -(AW-8)'(lim))
			r = -lim;
		else
			r = q[CW-1:0];
		if (c.zero)
			r = '0;
		return r;
	endfunction

endpackage

// File: rtl/core/qte_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_in_if
// Input channel: one quaternion item in Q1.14 per handshake.
// ----------------------------------------------------------------------------
interface qte_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] q_w;
	logic signed [15:0] q_x;
	logic signed [15:0] q_y;
	logic signed [15:0] q_z;

	modport source(output valid, output q_w, output q_x, output q_y, output q_z,
		input ready);
	modport sink(input valid, input q_w, input q_x, input q_y, input q_z,
		output ready);
endinterface

// File: rtl/core/qte_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_out_if
// Output channel: three angles at 128 counts per degree per handshake.
// ----------------------------------------------------------------------------
interface qte_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] angle_first;
	logic signed [15:0] angle_second;
	logic signed [14:0] angle_third;

	modport source(output valid, output angle_first, output angle_second,
		output angle_third, input ready);
	modport sink(input valid, input angle_first, input angle_second,
		input angle_third, output ready);
endinterface

// File: rtl/core/qte_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_front
// Three stages: quaternion products, rotation matrix terms, and the radicand
// 1 - s^2 for the cosine of the pitch.
// ----------------------------------------------------------------------------
module qte_front (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [15:0]            q_w,
	input  logic signed [15:0]            q_x,
	input  logic signed [15:0]            q_y,
	input  logic signed [15:0]            q_z,
	output logic [qte_pkg::SQW-1:0]       rad,
	output qte_pkg::side_t                side
);

	logic signed [31:0] ww_s1, xx_s1, zz_s1, xy_s1, wz_s1, yz_s1, wx_s1, xz_s1, wy_s1;
	qte_pkg::side_t side_s2, side_s3;
	logic [qte_pkg::SQW-1:0] rad_s3;

	qte_pkg::term_t s_raw;
	logic signed [qte_pkg::SW-1:0] s_clamp;
	logic [qte_pkg::SW-2:0] s_abs;
	logic [qte_pkg::SQW-1:0] s_sq;

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= q_w * q_w;
			xx_s1 <= q_x * q_x;
			zz_s1 <= q_z * q_z;
			xy_s1 <= q_x * q_y;
			wz_s1 <= q_w * q_z;
			yz_s1 <= q_y * q_z;
			wx_s1 <= q_w * q_x;
			xz_s1 <= q_x * q_z;
			wy_s1 <= q_w * q_y;
		end
	end

	// The asin argument is held to the closed interval of one.
	always_comb begin
		s_raw = (qte_pkg::TW'(xz_s1) + qte_pkg::TW'(wy_s1)) <<< 1;
		if (s_raw > qte_pkg::TW'(1 << 28))
			s_clamp = qte_pkg::SW'(1 << 28);
		else if (s_raw < -qte_pkg::TW'(1 << 28))
			s_clamp = -qte_pkg::SW'(1 << 28);
		else
			s_clamp = s_raw[qte_pkg::SW-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.s     <= s_clamp;
			side_s2.yaw_n <= (qte_pkg::TW'(xy_s1) - qte_pkg::TW'(wz_s1)) <<< 1;
			side_s2.yaw_d <= ((qte_pkg::TW'(ww_s1) + qte_pkg::TW'(xx_s1)) <<< 1)
				- qte_pkg::TW'(1 << 28);
			side_s2.rol_n <= (qte_pkg::TW'(yz_s1) - qte_pkg::TW'(wx_s1)) <<< 1;
			side_s2.rol_d <= ((qte_pkg::TW'(ww_s1) + qte_pkg::TW'(zz_s1)) <<< 1)
				- qte_pkg::TW'(1 << 28);
		end
	end

	always_comb begin
		if (side_s2.s < 0)
			s_abs = (qte_pkg::SW-1)'(-side_s2.s);
		else
			s_abs = side_s2.s[qte_pkg::SW-2:0];
		s_sq = qte_pkg::SQW'(s_abs) * qte_pkg::SQW'(s_abs);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			rad_s3  <= (qte_pkg::SQW'(1) << 56) - s_sq;
		end
	end

	assign rad  = rad_s3;
	assign side = side_s3;

endmodule

// File: rtl/core/qte_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// One step of the digit by digit integer square root, with side data that
// travels alongside.
// ----------------------------------------------------------------------------
module qte_sqrt_cell #(
	parameter int SH = 56,
	parameter int PW = 8
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [qte_pkg::SQW-1:0] rem_in,
	input  logic [qte_pkg::SQW-1:0] root_in,
	input  logic [PW-1:0]           side_in,
	output logic [qte_pkg::SQW-1:0] rem_out,
	output logic [qte_pkg::SQW-1:0] root_out,
	output logic [PW-1:0]           side_out
);

	localparam logic [qte_pkg::SQW-1:0] BIT = qte_pkg::SQW'(1) << SH;

	logic [qte_pkg::SQW-1:0] trial, rem_nx, root_nx;

	always_comb begin
		trial = root_in + BIT;
		if (rem_in >= trial) begin
			rem_nx  = rem_in - trial;
			root_nx = (root_in >> 1) + BIT;
		end else begin
			rem_nx  = rem_in;
			root_nx = root_in >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= rem_nx;
			root_out <= root_nx;
			side_out <= side_in;
		end
	end

endmodule

// File: rtl/core/qte_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring step of the CORDIC arctangent for a single lane.
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           en,
	input  qte_pkg::cord_t cin,
	output qte_pkg::cord_t cout
);

	localparam logic signed [qte_pkg::AW-1:0] ANG =
		qte_pkg::AW'(qte_pkg::ATAN_TAB[STEP]);

	logic signed [qte_pkg::XW-1:0] xs, ys;
	qte_pkg::cord_t nx;

	always_comb begin
		xs = cin.x >>> STEP;
		ys = cin.y >>> STEP;
		nx = cin;
		if (cin.y > 0) begin
			nx.x   = cin.x + ys;
			nx.y   = cin.y - xs;
			nx.acc = cin.acc + ANG;
		end else begin
			nx.x   = cin.x - ys;
			nx.y   = cin.y + xs;
			nx.acc = cin.acc - ANG;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cout <= nx;
		end
	end

endmodule

// File: rtl/core/quaternion_to_euler_degrees_unit.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle while the output queue has room; every stage is a
// cell in a fixed chain. An accepted item passes the front stages, the 29 square
// root cells and the 22 CORDIC cells in series before it enters the output queue.
// A two-entry output queue lets the pipeline go on while a result waits.
// Reset clears the stage valid bits and the queue count; data registers keep
// whatever they hold.
// ----------------------------------------------------------------------------
// quaternion_to_euler_degrees_unit
// Converts a unit quaternion in Q1.14 into negated roll, yaw and negated pitch
// in degrees at 128 counts per degree, with fixed point CORDIC arithmetic.
// ----------------------------------------------------------------------------
module quaternion_to_euler_degrees_unit (
	input  logic        clk,
	input  logic        arst_n,
	qte_in_if.sink      in_ch,
	qte_out_if.source   out_ch
);

	localparam int NST  = qte_pkg::NST;
	localparam int NSQ  = qte_pkg::NSQ;
	localparam int NCOR = qte_pkg::NCOR;
	localparam int PW   = $bits(qte_pkg::side_t);

	// The whole chain moves together whenever the output queue has room.
	logic adv;
	logic [NST-1:0] vld_q;

	logic [1:0] cnt_q;
	logic signed [15:0] e0_first_q, e0_second_q, e1_first_q, e1_second_q;
	logic signed [14:0] e0_third_q, e1_third_q;
	logic push, pop;

	assign adv = (cnt_q != 2'd2);
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], in_ch.valid};
		end
	end

	// Products, terms and the radicand for the cosine of the pitch.
	logic [qte_pkg::SQW-1:0] rem_c  [NSQ+1];
	logic [qte_pkg::SQW-1:0] root_c [NSQ+1];
	logic [PW-1:0]           side_c [NSQ+1];
	qte_pkg::side_t          front_side;

	qte_front u_front (
		.clk  (clk),
		.en   (adv),
		.q_w  (in_ch.q_w),
		.q_x  (in_ch.q_x),
		.q_y  (in_ch.q_y),
		.q_z  (in_ch.q_z),
		.rad  (rem_c[0]),
		.side (front_side)
	);

	assign root_c[0] = '0;
	assign side_c[0] = front_side;

	// The square root resolves one result bit in each cell, top bit first.
	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		qte_sqrt_cell #(
			.SH (2 * (NSQ - 1 - k)),
			.PW (PW)
		) u_cell (
			.clk      (clk),
			.en       (adv),
			.rem_in   (rem_c[k]),
			.root_in  (root_c[k]),
			.side_in  (side_c[k]),
			.rem_out  (rem_c[k+1]),
			.root_out (root_c[k+1]),
			.side_out (side_c[k+1])
		);
	end

	// Lane 0 carries roll, lane 1 yaw and lane 2 the asin of the pitch term.
	qte_pkg::side_t sq_side;
	logic signed [qte_pkg::XW-1:0] cos_x;
	qte_pkg::cord_t cor_c [NCOR+1][qte_pkg::NLANE];

	assign sq_side = qte_pkg::side_t'(side_c[NSQ]);
	assign cos_x   = qte_pkg::XW'({1'b0, root_c[NSQ][28:0]});

	always_ff @(posedge clk) begin
		if (adv) begin
			cor_c[0][0] <= qte_pkg::pre_rotate(qte_pkg::XW'(sq_side.rol_n),
				qte_pkg::XW'(sq_side.rol_d));
			cor_c[0][1] <= qte_pkg::pre_rotate(qte_pkg::XW'(sq_side.yaw_n),
				qte_pkg::XW'(sq_side.yaw_d));
			cor_c[0][2] <= qte_pkg::pre_rotate(qte_pkg::XW'(sq_side.s), cos_x);
		end
	end

	for (genvar i = 0; i < NCOR; i++) begin : g_cordic
		for (genvar l = 0; l < qte_pkg::NLANE; l++) begin : g_lane
			qte_cordic_cell #(
				.STEP (i)
			) u_cell (
				.clk  (clk),
				.en   (adv),
				.cin  (cor_c[i][l]),
				.cout (cor_c[i+1][l])
			);
		end
	end

	// Rounding to 1/128 degree, clamping, and the sign change of roll.
	logic signed [qte_pkg::CW-1:0] roll_c, yaw_c, pitch_c;
	logic signed [qte_pkg::CW-1:0] nroll;
	logic signed [15:0] first_s, second_s;
	logic signed [14:0] third_s;

	always_comb begin
		roll_c  = qte_pkg::to_counts(cor_c[NCOR][0], qte_pkg::LIM_WIDE);
		yaw_c   = qte_pkg::to_counts(cor_c[NCOR][1], qte_pkg::LIM_WIDE);
		pitch_c = qte_pkg::to_counts(cor_c[NCOR][2], qte_pkg::LIM_NARROW);
		nroll   = -roll_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_s  <= nroll[15:0];
			second_s <= yaw_c[15:0];
			third_s  <= pitch_c[14:0];
		end
	end

	// Two-entry output queue; entry 0 is the head.
	assign push = adv && vld_q[NST-1];
	assign pop  = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && cnt_q == 2'd1) begin
				e0_first_q  <= first_s;
				e0_second_q <= second_s;
				e0_third_q  <= third_s;
			end else begin
				e0_first_q  <= e1_first_q;
				e0_second_q <= e1_second_q;
				e0_third_q  <= e1_third_q;
			end
			if (push && cnt_q == 2'd2) begin
				e1_first_q  <= first_s;
				e1_second_q <= second_s;
				e1_third_q  <= third_s;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				e0_first_q  <= first_s;
				e0_second_q <= second_s;
				e0_third_q  <= third_s;
			end else begin
				e1_first_q  <= first_s;
				e1_second_q <= second_s;
				e1_third_q  <= third_s;
			end
		end
	end

	assign out_ch.valid        = (cnt_q != 2'd0);
	assign out_ch.angle_first  = e0_first_q;
	assign out_ch.angle_second = e0_second_q;
	assign out_ch.angle_third  = e0_third_q;

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue count out of range");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !in_ch.ready)
		else $error("input taken while output queue full");

	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NST-1] && !adv) |=> vld_q[NST-1])
		else $error("finished item lost during stall");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push && cnt_q == 2'd1) |=> !out_ch.valid)
		else $error("output queue did not drain");
`endif

endmodule
